// ----- src/cfc_pkg.sv -----
// Shared types, codes and the byte-wise CRC-32 update for the frame checker.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package cfc_pkg;

  typedef enum logic [1:0] {
    PH_HEADER  = 2'd0,
    PH_PAYLOAD = 2'd1,
    PH_CRC     = 2'd2
  } phase_t;

  typedef enum logic [1:0] {
    KIND_DATA = 2'd0,
    KIND_GOOD = 2'd1,
    KIND_BAD  = 2'd2,
    KIND_LEN  = 2'd3
  } kind_t;

  typedef struct packed {
    logic [7:0] payload_byte;
    kind_t      result_kind;
    logic       frame_end;
  } res_t;

  localparam logic [31:0] CRC_POLY = 32'hEDB88320;
  localparam logic [31:0] CRC_INIT = 32'hFFFFFFFF;

  // Reflected CRC-32, one byte, bit at a time.
  function automatic logic [31:0] crc_byte(input logic [31:0] c_in, input logic [7:0] b);
    logic [31:0] c;
    c = c_in ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage
`default_nettype wire

// ----- src/cfc_frame_fsm.sv -----
// Frame parser: header length, payload count, running CRC and status decision.
// Depends on cfc_pkg.
`timescale 1ns / 1ps
`default_nettype none
module cfc_frame_fsm import cfc_pkg::*; #(
  parameter int unsigned MaxPayload = 65536,
  parameter int          LenW       = 17
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       fire,
  input  wire logic [7:0] byte_in,
  output logic            has_result,
  output res_t            result
);

  phase_t          phase, phase_next;
  logic [1:0]      byte_index, byte_index_next;
  logic [23:0]     field_lo, field_lo_next;
  logic [LenW-1:0] bytes_left, bytes_left_next;
  logic [31:0]     crc_running, crc_running_next;
  logic [31:0]     field_full;

  assign field_full = {byte_in, field_lo};

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_HEADER;
      byte_index  <= '0;
      field_lo    <= '0;
      bytes_left  <= '0;
      crc_running <= CRC_INIT;
    end else if (fire) begin
      phase       <= phase_next;
      byte_index  <= byte_index_next;
      field_lo    <= field_lo_next;
      bytes_left  <= bytes_left_next;
      crc_running <= crc_running_next;
    end
  end

  always_comb begin
    phase_next       = phase;
    byte_index_next  = byte_index + 2'd1;
    field_lo_next    = field_lo;
    bytes_left_next  = bytes_left;
    crc_running_next = crc_running;
    has_result       = 1'b0;
    result           = '{payload_byte: 8'd0, result_kind: KIND_DATA, frame_end: 1'b0};
    case (phase)
      PH_PAYLOAD: begin
        has_result       = 1'b1;
        result           = '{payload_byte: byte_in, result_kind: KIND_DATA, frame_end: 1'b0};
        crc_running_next = crc_byte(crc_running, byte_in);
        bytes_left_next  = bytes_left - LenW'(1);
        byte_index_next  = '0;
        if (bytes_left == LenW'(1)) begin
          phase_next    = PH_CRC;
          field_lo_next = '0;
        end
      end
      PH_CRC: begin
        case (byte_index)
          2'd0: field_lo_next[7:0]   = byte_in;
          2'd1: field_lo_next[15:8]  = byte_in;
          2'd2: field_lo_next[23:16] = byte_in;
          default: begin
            has_result       = 1'b1;
            result.frame_end = 1'b1;
            result.result_kind = (field_full == ~crc_running) ? KIND_GOOD : KIND_BAD;
            phase_next       = PH_HEADER;
            field_lo_next    = '0;
            bytes_left_next  = '0;
            crc_running_next = CRC_INIT;
          end
        endcase
      end
      default: begin
        case (byte_index)
          2'd0: field_lo_next[7:0]   = byte_in;
          2'd1: field_lo_next[15:8]  = byte_in;
          2'd2: field_lo_next[23:16] = byte_in;
          default: begin
            field_lo_next    = '0;
            crc_running_next = CRC_INIT;
            if (field_full > 32'(MaxPayload)) begin
              has_result       = 1'b1;
              result.frame_end = 1'b1;
              result.result_kind = KIND_LEN;
              phase_next       = PH_HEADER;
              bytes_left_next  = '0;
            end else begin
              bytes_left_next = field_full[LenW-1:0];
              phase_next      = (field_full == 32'd0) ? PH_CRC : PH_PAYLOAD;
            end
          end
        endcase
      end
    endcase
  end

endmodule
`default_nettype wire

// ----- src/cfc_out_reg.sv -----
// Result register holding one result transfer until the receiver takes it.
// Depends on cfc_pkg.
`timescale 1ns / 1ps
`default_nettype none
module cfc_out_reg import cfc_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic load,
  input  wire res_t res_in,
  input  wire logic take,
  output logic      valid,
  output res_t      res_out
);

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (load) begin
      valid <= 1'b1;
    end else if (take) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_out <= res_in;
    end
  end

endmodule
`default_nettype wire

// ----- src/crc32_frame_checker.sv -----
// CRC-32 frame checker top level: input register, frame parser, result register.
// Depends on cfc_pkg, cfc_frame_fsm, cfc_out_reg.
//
// Usage:
//   rx channel (rx_valid/rx_ready/rx_byte) carries the framed byte stream:
//   4-byte little-endian length, payload, 4-byte little-endian CRC-32.
//   out channel (out_valid/out_ready) carries results: each payload byte
//   (result_kind data), and one status transfer per frame (good, CRC
//   mismatch, or length above MAX_PAYLOAD) with frame_end high.
//   Header bytes give no result but for the last one of a length above
//   MAX_PAYLOAD; the first three CRC bytes give no result. A result goes
//   through the input register, then the result register. Throughput:
//   one byte per cycle while the receiver does not stall; the byte-wise
//   CRC update and the counters are combinational between the two registers.
//   When the receiver stalls, the held result stays in the result register
//   and the next byte that has a result waits in the input register;
//   rx_ready then drops.
//   Synchronous reset empties both registers and returns the parser to
//   waiting for a header with the CRC at all ones.
`timescale 1ns / 1ps
`default_nettype none
module crc32_frame_checker import cfc_pkg::*; #(
  parameter int unsigned MAX_PAYLOAD = 65536
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       rx_valid,
  output logic            rx_ready,
  input  wire logic [7:0] rx_byte,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [7:0]      payload_byte,
  output logic [1:0]      result_kind,
  output logic            frame_end
);

  localparam int LenW = $clog2(64'(MAX_PAYLOAD) + 64'd1);

  logic       held_valid;
  logic [7:0] held_byte;
  logic       advance;
  logic       has_result;
  res_t       result;
  res_t       res_out;

  assign advance  = held_valid && (!has_result || !out_valid || out_ready);
  assign rx_ready = !held_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (rx_ready) begin
      held_valid <= rx_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rx_valid && rx_ready) begin
      held_byte <= rx_byte;
    end
  end

  cfc_frame_fsm #(
    .MaxPayload(MAX_PAYLOAD),
    .LenW      (LenW)
  ) u_fsm (
    .clk       (clk),
    .rst       (rst),
    .fire      (advance),
    .byte_in   (held_byte),
    .has_result(has_result),
    .result    (result)
  );

  cfc_out_reg u_out (
    .clk    (clk),
    .rst    (rst),
    .load   (advance && has_result),
    .res_in (result),
    .take   (out_ready),
    .valid  (out_valid),
    .res_out(res_out)
  );

  assign payload_byte = res_out.payload_byte;
  assign result_kind  = res_out.result_kind;
  assign frame_end    = res_out.frame_end;

endmodule
`default_nettype wire

// ----- src/cfc_port_checker.sv -----
// Port-level checks for the CRC-32 frame checker, bound to the top level.
// Depends on cfc_pkg and crc32_frame_checker.
`timescale 1ns / 1ps
`default_nettype none
module cfc_port_checker import cfc_pkg::*; (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic [7:0] payload_byte,
  input wire logic [1:0] result_kind,
  input wire logic       frame_end
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(payload_byte)
      && $stable(result_kind) && $stable(frame_end))
    else $error("result changed while stalled");

  a_end_kind: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (frame_end == (result_kind != KIND_DATA)))
    else $error("frame_end disagrees with result kind");

  a_status_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && frame_end |-> payload_byte == 8'd0)
    else $error("status transfer carries nonzero data");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind crc32_frame_checker cfc_port_checker u_cfc_port_checker (
  .clk         (clk),
  .rst         (rst),
  .out_valid   (out_valid),
  .out_ready   (out_ready),
  .payload_byte(payload_byte),
  .result_kind (result_kind),
  .frame_end   (frame_end)
);
`default_nettype wire
